// File: rtl/rect_fill_engine_top_assert.svh
// Assertion macros for the rectangle fill engine RTL.
// Depends on nothing; included by rfe_back, the module that checks its own logic.
`ifndef RECT_FILL_ENGINE_TOP_ASSERT_SVH
`define RECT_FILL_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RFE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("rect fill engine assertion failed");
`define RFE_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
   else $error("rect fill engine assertion failed");
`else
`define RFE_ASSERT(lbl, clk, rst, prop)
`define RFE_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: rtl/rfe_pkg.sv
// Shared types and constants of the rectangle fill engine.
// Used by every module of the block; depends on nothing.
package rfe_pkg;

   localparam int ADDR_WIDTH_DEF  = 32;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int ADDR_MAX        = 32;
   localparam int COORD_MAX       = 16;
   localparam int PIXEL_W         = 16;
   localparam int MID_DEPTH       = 4;
   localparam int OUT_DEPTH       = 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES  = 3'd4;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_RANGE  = 3'd1,
      ST_ZERO   = 3'd2,
      ST_ALIGN  = 3'd3,
      ST_STRIDE = 3'd4,
      ST_BUSY   = 3'd5
   } status_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] stride;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] bytes;
   } cfg_type;

   // A classified item on its way from the front to the back.
   typedef struct packed {
      logic                 func;
      status_type           code;
      logic [ADDR_MAX-1:0]  addr;
      logic [COORD_MAX-1:0] width;
      logic [COORD_MAX-1:0] height;
      logic [PIXEL_W-1:0]   color;
   } cmd_type;

   typedef struct packed {
      status_type          status;
      logic                write_valid;
      logic [ADDR_MAX-1:0] address;
      logic [PIXEL_W-1:0]  pixel;
      logic                done;
   } res_type;

endpackage

// File: rtl/rfe_cmd_fifo.sv
// Short command queue between the front and the back of the fill engine.
// Depends on rfe_pkg for the command type.
module rfe_cmd_fifo import rfe_pkg::*; #(
   parameter int DEPTH = MID_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  cmd_type                      push_data,
   input  logic                         pop,
   output cmd_type                      pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (cnt_ff == '0);
   assign count    = cnt_ff;

endmodule

// File: rtl/rfe_front.sv
// Front of the fill engine: registers each item and classifies start commands
// against the surface. Depends on rfe_pkg; feeds rfe_cmd_fifo.
module rfe_front import rfe_pkg::*; #(
   parameter int AW = ADDR_MAX,
   parameter int CW = COORD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic          func,
   input  logic [15:0]   rect_x,
   input  logic [15:0]   rect_y,
   input  logic [15:0]   rect_width,
   input  logic [15:0]   rect_height,
   input  logic [15:0]   fill_color,
   input  cfg_type       cfg,
   output logic          cmd_valid,
   output cmd_type       cmd
);

   localparam int PW = CW + 32;

   logic [CW-1:0]  x, y, w, h, sw, sh, sh_m1;
   logic [CW:0]    sw2;
   status_type     s1_code_in;
   logic           s1_xybad_in;
   logic [PW-1:0]  s1_pext_in, s1_py_in;

   logic           s1_vld_ff;
   logic           s1_func_ff;
   status_type     s1_code_ff;
   logic           s1_xybad_ff;
   logic [PW-1:0]  s1_pext_ff, s1_py_ff;
   logic [CW-1:0]  s1_x_ff, s1_w_ff, s1_h_ff;
   logic [15:0]    s1_color_ff;

   logic [PW:0]    extent;
   logic [PW+1:0]  top_sum;
   logic           ext_bad, top_bad;
   logic [AW-1:0]  start_addr;
   status_type     code;

   assign x     = rect_x[CW-1:0];
   assign y     = rect_y[CW-1:0];
   assign w     = rect_width[CW-1:0];
   assign h     = rect_height[CW-1:0];
   assign sw    = cfg.width[CW-1:0];
   assign sh    = cfg.height[CW-1:0];
   assign sh_m1 = sh - 1'b1;
   assign sw2   = {sw, 1'b0};

   // Checks that need no product, in their order of priority.
   always_comb begin
      if (cfg.base == '0) begin
         s1_code_in = ST_RANGE;
      end else if (w == '0 || h == '0 || sw == '0 || sh == '0) begin
         s1_code_in = ST_ZERO;
      end else if (cfg.base[0] || cfg.stride[0]) begin
         s1_code_in = ST_ALIGN;
      end else if (cfg.stride < 32'(sw2)) begin
         s1_code_in = ST_STRIDE;
      end else begin
         s1_code_in = ST_OK;
      end
   end

   assign s1_xybad_in = ((CW+1)'(x) + (CW+1)'(w) > (CW+1)'(sw)) ||
                        ((CW+1)'(y) + (CW+1)'(h) > (CW+1)'(sh));
   assign s1_pext_in  = PW'(sh_m1) * PW'(cfg.stride);
   assign s1_py_in    = PW'(y) * PW'(cfg.stride);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_func_ff  <= func;
         s1_code_ff  <= s1_code_in;
         s1_xybad_ff <= s1_xybad_in;
         s1_pext_ff  <= s1_pext_in;
         s1_py_ff    <= s1_py_in;
         s1_x_ff     <= x;
         s1_w_ff     <= w;
         s1_h_ff     <= h;
         s1_color_ff <= fill_color;
      end
   end

   // Second half: extent and address-space checks, and the first pixel address.
   assign extent     = (PW+1)'(s1_pext_ff) + (PW+1)'(sw2);
   assign ext_bad    = extent > (PW+1)'(cfg.bytes);
   assign top_sum    = (PW+2)'(cfg.base) + (PW+2)'(extent) - (PW+2)'(1);
   assign top_bad    = (top_sum >> AW) != '0;
   assign start_addr = AW'(cfg.base) + AW'(s1_py_ff) + AW'({s1_x_ff, 1'b0});

   always_comb begin
      if (s1_code_ff != ST_OK) begin
         code = s1_code_ff;
      end else if (ext_bad || top_bad || s1_xybad_ff) begin
         code = ST_RANGE;
      end else begin
         code = ST_OK;
      end
   end

   always_comb begin
      cmd.func   = s1_func_ff;
      cmd.code   = code;
      cmd.addr   = ADDR_MAX'(start_addr);
      cmd.width  = COORD_MAX'(s1_w_ff);
      cmd.height = COORD_MAX'(s1_h_ff);
      cmd.color  = s1_color_ff;
   end

   assign cmd_valid = s1_vld_ff;

endmodule

// File: rtl/rfe_back.sv
// Back of the fill engine: runs the fill state and buffers results.
// Depends on rfe_pkg and the assertion macros header.
`include "rect_fill_engine_top_assert.svh"

module rfe_back import rfe_pkg::*; #(
   parameter int AW = ADDR_MAX,
   parameter int CW = COORD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cmd_type       head,
   output logic          take,
   input  logic [31:0]   stride,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output res_type       rsp
);

   localparam int OPW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int OCW = $clog2(OUT_DEPTH+1);

   logic           busy_ff, busy_in;
   logic [AW-1:0]  row_addr_ff, row_addr_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  rows_ff, rows_in;
   logic [CW-1:0]  lw_ff, lw_in;
   logic [15:0]    lc_ff, lc_in;

   res_type        out_mem_ff [OUT_DEPTH];
   logic [OPW-1:0] out_wr_ff, out_wr_in;
   logic [OPW-1:0] out_rd_ff, out_rd_in;
   logic [OCW-1:0] out_cnt_ff, out_cnt_in;

   res_type        res_in;
   logic [CW:0]    col1;
   logic           wrap, last;
   logic           room, out_pop;

   assign rsp_empty = (out_cnt_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;
   assign room      = (out_cnt_ff != OCW'(OUT_DEPTH)) || rsp_pop;
   assign take      = head_valid && room;

   assign col1 = {1'b0, col_ff} + 1'b1;
   assign wrap = col1 >= {1'b0, lw_ff};
   assign last = wrap && (rows_ff <= CW'(1));

   always_comb begin
      busy_in     = busy_ff;
      row_addr_in = row_addr_ff;
      col_in      = col_ff;
      rows_in     = rows_ff;
      lw_in       = lw_ff;
      lc_in       = lc_ff;
      res_in      = '0;
      if (take) begin
         if (head.func == FUNC_START) begin
            if (busy_ff) begin
               res_in.status = ST_BUSY;
            end else begin
               res_in.status = head.code;
               if (head.code == ST_OK) begin
                  busy_in     = 1'b1;
                  row_addr_in = head.addr[AW-1:0];
                  col_in      = '0;
                  rows_in     = head.height[CW-1:0];
                  lw_in       = head.width[CW-1:0];
                  lc_in       = head.color;
               end
            end
         end else if (busy_ff) begin
            res_in.write_valid = 1'b1;
            res_in.address     = ADDR_MAX'(row_addr_ff + AW'({col_ff, 1'b0}));
            res_in.pixel       = lc_ff;
            res_in.done        = last;
            if (wrap) begin
               // End of a row: step down one stride and count the row off.
               col_in      = '0;
               rows_in     = rows_ff - 1'b1;
               row_addr_in = row_addr_ff + AW'(stride);
               if (rows_ff == CW'(1)) begin
                  busy_in = 1'b0;
               end
            end else begin
               col_in = col1[CW-1:0];
            end
         end
      end
   end

   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (take) begin
         out_wr_in = (out_wr_ff == OPW'(OUT_DEPTH-1)) ? '0 : out_wr_ff + 1'b1;
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == OPW'(OUT_DEPTH-1)) ? '0 : out_rd_ff + 1'b1;
      end
      if (take && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (!take && out_pop) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      row_addr_ff <= row_addr_in;
      col_ff      <= col_in;
      rows_ff     <= rows_in;
      lw_ff       <= lw_in;
      lc_ff       <= lc_in;
      if (take) begin
         out_mem_ff[out_wr_ff] <= res_in;
      end
   end

   assign rsp = out_mem_ff[out_rd_ff];

   `RFE_ASSERT(a_last_write_ends_fill, clock, reset, take && head.func == FUNC_TICK && busy_ff && last |=> !busy_ff)
   `RFE_ASSERT(a_busy_start_keeps_fill, clock, reset, take && head.func == FUNC_START && busy_ff |=> busy_ff)
   `RFE_ASSERT(a_write_only_when_busy, clock, reset, take && res_in.write_valid |-> busy_ff)
   `RFE_ASSERT(a_no_take_when_full, clock, reset, out_cnt_ff == OCW'(OUT_DEPTH) && !rsp_pop |-> !take)
   `RFE_ASSERT_NR(a_out_count_bound, clock, reset || out_cnt_ff <= OCW'(OUT_DEPTH))

endmodule

// File: rtl/rect_fill_engine_top.sv
// Rectangle fill engine: each accepted item yields one result, and the engine sustains
// one item per cycle, pixel writes included, while req_full is low and results are popped.
// Items pass the front's multiply register, the command queue and the back's fill step;
// the command queue lets the back stall without losing a beat.
// Reset is synchronous: configuration clears to zero, the engine goes idle and
// both queues empty at once.
module rect_fill_engine_top import rfe_pkg::*; #(
   parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_func,
   input  logic [15:0]               req_rect_x,
   input  logic [15:0]               req_rect_y,
   input  logic [15:0]               req_rect_width,
   input  logic [15:0]               req_rect_height,
   input  logic [15:0]               req_fill_color,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [2:0]                rsp_status,
   output logic                      rsp_write_valid,
   output logic [((ADDR_WIDTH < ADDR_MAX) ? ADDR_WIDTH : ADDR_MAX)-1:0] rsp_write_address,
   output logic [15:0]               rsp_write_pixel,
   output logic                      rsp_fill_done,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int AW   = (ADDR_WIDTH < ADDR_MAX) ? ADDR_WIDTH : ADDR_MAX;
   localparam int MCW  = $clog2(MID_DEPTH+1);

   cfg_type          cfg_ff, cfg_in;
   logic             in_take;
   logic             cmd_valid;
   cmd_type          cmd, head;
   logic             head_empty;
   logic             head_take;
   logic [MCW-1:0]   mid_cnt;
   res_type          rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BASE:   cfg_in.base   = csr_data;
            CSR_STRIDE: cfg_in.stride = csr_data;
            CSR_WIDTH:  cfg_in.width  = csr_data[15:0];
            CSR_HEIGHT: cfg_in.height = csr_data[15:0];
            CSR_BYTES:  cfg_in.bytes  = csr_data;
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Items in the front stage count against the queue so the front never stalls.
   assign req_full = ((MCW+1)'(mid_cnt) + (MCW+1)'(cmd_valid)) >= (MCW+1)'(MID_DEPTH);
   assign in_take  = req_push && !req_full;

   rfe_front #(
      .AW (AW),
      .CW (COORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (in_take),
      .func        (req_func),
      .rect_x      (req_rect_x),
      .rect_y      (req_rect_y),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .fill_color  (req_fill_color),
      .cfg         (cfg_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   rfe_cmd_fifo #(
      .DEPTH (MID_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd),
      .pop       (head_take),
      .pop_data  (head),
      .empty     (head_empty),
      .count     (mid_cnt)
   );

   rfe_back #(
      .AW (AW),
      .CW (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!head_empty),
      .head       (head),
      .take       (head_take),
      .stride     (cfg_ff.stride),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp)
   );

   assign rsp_status        = rsp.status;
   assign rsp_write_valid   = rsp.write_valid;
   assign rsp_write_address = rsp.address[AW-1:0];
   assign rsp_write_pixel   = rsp.pixel;
   assign rsp_fill_done     = rsp.done;

endmodule

// File: tb/sv/rect_fill_checker.sv
// Checker for the rectangle fill engine: follows the request, response and CSR ports,
// predicts every response beat and compares it field by field.
// Depends on rfe_pkg for the status codes, CSR indexes and the result layout.
module rect_fill_checker
   import rfe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  logic                   req_func,
   input  logic [15:0]            req_rect_x,
   input  logic [15:0]            req_rect_y,
   input  logic [15:0]            req_rect_width,
   input  logic [15:0]            req_rect_height,
   input  logic [15:0]            req_fill_color,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  logic [2:0]             rsp_status,
   input  logic                   rsp_write_valid,
   input  logic [31:0]            rsp_write_address,
   input  logic [15:0]            rsp_write_pixel,
   input  logic                   rsp_fill_done,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     outcomes_waiting,
   output int                     beats_checked,
   output int                     pixels_checked,
   output int                     fills_started,
   output int                     starts_refused
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] surf_base, surf_stride, surf_bytes;
   logic [15:0] surf_width, surf_height;

   logic        filling;
   logic [31:0] row_addr;
   logic [15:0] col_pos, rows_to_go, fill_w, fill_rgb;

   res_type     outcomes_due[$];

   function automatic status_type try_start(input logic [15:0] x, y, w, h, rgb);
      logic [63:0] extent, base64, stride64;
      base64   = {32'd0, surf_base};
      stride64 = {32'd0, surf_stride};
      if (filling) return ST_BUSY;
      if (surf_base == '0) return ST_RANGE;
      if (w == '0 || h == '0 || surf_width == '0 || surf_height == '0) return ST_ZERO;
      if (surf_base[0] || surf_stride[0]) return ST_ALIGN;
      if (stride64 < {47'd0, surf_width, 1'b0}) return ST_STRIDE;
      extent = ({48'd0, surf_height} - 64'd1) * stride64 + {47'd0, surf_width, 1'b0};
      if (extent > {32'd0, surf_bytes}) return ST_RANGE;
      if (base64 + extent - 64'd1 > 64'h0000_0000_FFFF_FFFF) return ST_RANGE;
      if ({1'b0, x} + {1'b0, w} > {1'b0, surf_width} ||
          {1'b0, y} + {1'b0, h} > {1'b0, surf_height}) return ST_RANGE;
      filling    = 1'b1;
      row_addr   = 32'(base64 + {48'd0, y} * stride64 + {47'd0, x, 1'b0});
      col_pos    = '0;
      rows_to_go = h;
      fill_w     = w;
      fill_rgb   = rgb;
      return ST_OK;
   endfunction

   // One beat in, one result out; a tick advances the running fill by one pixel.
   function automatic res_type fill_outcome(input logic func,
                                            input logic [15:0] x, y, w, h, rgb);
      res_type     r;
      logic [16:0] next_col;
      r        = '0;
      r.status = ST_OK;
      if (func == FUNC_START) begin
         r.status = try_start(x, y, w, h, rgb);
         return r;
      end
      if (!filling) return r;
      next_col      = {1'b0, col_pos} + 17'd1;
      r.write_valid = 1'b1;
      r.address     = row_addr + {15'd0, col_pos, 1'b0};
      r.pixel       = fill_rgb;
      r.done        = (next_col >= {1'b0, fill_w}) && (rows_to_go <= 16'd1);
      col_pos       = next_col[15:0];
      if (col_pos >= fill_w) begin
         col_pos    = '0;
         rows_to_go = rows_to_go - 16'd1;
         // The stride is read at each row advance, so a rewrite mid-fill takes effect here.
         row_addr   = row_addr + surf_stride;
         if (rows_to_go == '0) filling = 1'b0;
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         surf_base   = '0;
         surf_stride = '0;
         surf_width  = '0;
         surf_height = '0;
         surf_bytes  = '0;
         filling     = 1'b0;
         row_addr    = '0;
         col_pos     = '0;
         rows_to_go  = '0;
         fill_w      = '0;
         fill_rgb    = '0;
         outcomes_due.delete();
      end else begin
         if (req_push && !req_full) begin
            want = fill_outcome(req_func, req_rect_x, req_rect_y, req_rect_width,
                                req_rect_height, req_fill_color);
            if (req_func == FUNC_START) begin
               if (want.status == ST_OK) fills_started++;
               else starts_refused++;
            end
            outcomes_due.push_back(want);
         end
         if (rsp_pop && !rsp_empty) begin
            if (outcomes_due.size() == 0) begin
               $error("response beat with nothing expected: status %0d, address %h",
                      rsp_status, rsp_write_address);
               mismatches++;
            end else begin
               want = outcomes_due.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("write_valid", 32'(want.write_valid), 32'(rsp_write_valid));
               compare_field("write_address", want.address, rsp_write_address);
               compare_field("write_pixel", 32'(want.pixel), 32'(rsp_write_pixel));
               compare_field("fill_done", 32'(want.done), 32'(rsp_fill_done));
               beats_checked++;
               if (want.write_valid) pixels_checked++;
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_BASE:   surf_base   = csr_data;
               CSR_STRIDE: surf_stride = csr_data;
               CSR_WIDTH:  surf_width  = csr_data[15:0];
               CSR_HEIGHT: surf_height = csr_data[15:0];
               CSR_BYTES:  surf_bytes  = csr_data;
               default: ;
            endcase
         end
      end
      outcomes_waiting <= outcomes_due.size();
   end

endmodule

// File: tb/sv/tb.sv
// Testbench top for rect_fill_engine_top: clock, reset, CSR programming, request and
// response traffic, and the verdict. Depends on rfe_pkg and rect_fill_checker.
module tb import rfe_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum int {
      POP_ALWAYS, POP_COIN, POP_THREE_OF_FOUR, POP_ONE_OF_THREE, POP_MOSTLY
   } pop_style_type;

   typedef enum int {
      FLAW_NONE, FLAW_NULL_BASE, FLAW_ODD_BASE, FLAW_ODD_STRIDE, FLAW_NARROW_STRIDE,
      FLAW_SHORT_BUFFER, FLAW_PAST_TOP, FLAW_NO_WIDTH, FLAW_NO_HEIGHT
   } surface_flaw_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic                   req_func = FUNC_TICK;
   logic [15:0]            req_rect_x = '0;
   logic [15:0]            req_rect_y = '0;
   logic [15:0]            req_rect_width = '0;
   logic [15:0]            req_rect_height = '0;
   logic [15:0]            req_fill_color = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [2:0]             rsp_status;
   logic                   rsp_write_valid;
   logic [31:0]            rsp_write_address;
   logic [15:0]            rsp_write_pixel;
   logic                   rsp_fill_done;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BASE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatches, outcomes_waiting, beats_checked, pixels_checked;
   int fills_started, starts_refused;

   int burst_left = 0;
   int flood_left = 0;
   int hold_asks = 0;
   int items_sent = 0;
   int settings_used = 0;

   rect_fill_engine_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_func(req_func),
      .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_fill_color(req_fill_color),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_status(rsp_status),
      .rsp_write_valid(rsp_write_valid), .rsp_write_address(rsp_write_address),
      .rsp_write_pixel(rsp_write_pixel), .rsp_fill_done(rsp_fill_done),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   rect_fill_checker u_fill_check (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_func(req_func),
      .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_fill_color(req_fill_color),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_status(rsp_status),
      .rsp_write_valid(rsp_write_valid), .rsp_write_address(rsp_write_address),
      .rsp_write_pixel(rsp_write_pixel), .rsp_fill_done(rsp_fill_done),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .outcomes_waiting(outcomes_waiting),
      .beats_checked(beats_checked), .pixels_checked(pixels_checked),
      .fills_started(fills_started), .starts_refused(starts_refused)
   );

   always #10 clock = ~clock;

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   // The receiver changes its pop rhythm every so often and honors hold-off requests.
   initial begin : pop_pattern
      pop_style_type style;
      int            style_left, hold_left, holds_seen, cycle;
      style      = POP_ALWAYS;
      style_left = 0;
      hold_left  = 0;
      holds_seen = 0;
      cycle      = 0;
      forever begin
         @(posedge clock);
         cycle++;
         if (holds_seen != hold_asks) begin
            holds_seen = hold_asks;
            hold_left  = 120;
         end
         if (style_left == 0) begin
            style      = pop_style_type'($urandom_range(0, 4));
            style_left = $urandom_range(16, 160);
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (style)
               POP_ALWAYS:        rsp_pop <= 1'b1;
               POP_COIN:          rsp_pop <= 1'($urandom_range(0, 1));
               POP_THREE_OF_FOUR: rsp_pop <= (cycle % 4 != 3);
               POP_ONE_OF_THREE:  rsp_pop <= (cycle % 3 == 0);
               default:           rsp_pop <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Offers one beat and returns at the edge that accepts it. Push stays high between
   // beats of a burst; a gap lowers it first.
   task automatic push_item(input logic func, input logic [15:0] x, y, w, h, rgb);
      if (burst_left == 0) begin
         if (flood_left == 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      if (flood_left > 0) flood_left--;
      req_func        <= func;
      req_rect_x      <= x;
      req_rect_y      <= y;
      req_rect_width  <= w;
      req_rect_height <= h;
      req_fill_color  <= rgb;
      req_push        <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic push_random(input logic func);
      push_item(func, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (outcomes_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic reg_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   // The upper half of the width and height words carries junk that must be ignored.
   task automatic set_surface(input logic [31:0] base, stride,
                              input logic [15:0] width, height,
                              input logic [31:0] bytes);
      drain();
      reg_write(CSR_BASE, base);
      reg_write(CSR_STRIDE, stride);
      reg_write(CSR_WIDTH, {16'($urandom), width});
      reg_write(CSR_HEIGHT, {16'($urandom), height});
      reg_write(CSR_BYTES, bytes);
      if ($urandom_range(0, 3) == 0) reg_write(CSR_UNUSED, $urandom);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int phase);
      logic [31:0]      base, stride, bytes;
      logic [15:0]      sw, sh, sw_reg, sh_reg;
      logic [63:0]      extent;
      surface_flaw_type flaw;
      int               budget, first, w, h, ticks;
      sw = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(1, 40));
      sh = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(1, 40));
      stride = 32'(sw) * 2 + 2 * $urandom_range(0, 8);
      extent = 64'(sh - 16'd1) * 64'(stride) + 64'(sw) * 2;
      if (extent > 64'hFFFF_0000) begin
         sh     = 16'd1;
         extent = 64'(sw) * 2;
      end
      case ($urandom_range(0, 3))
         0:       base = 32'(64'h1_0000_0000 - extent);
         1:       base = 2 * $urandom_range(1, 2048);
         default: base = 2 * $urandom_range(1, 32'((64'h1_0000_0000 - extent) / 2));
      endcase
      bytes = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF
                                          : 32'(extent) + $urandom_range(0, 64);
      sw_reg = sw;
      sh_reg = sh;
      flaw = ($urandom_range(0, 3) == 0) ? surface_flaw_type'($urandom_range(1, 8))
                                         : FLAW_NONE;
      case (flaw)
         FLAW_NULL_BASE:     base = '0;
         FLAW_ODD_BASE:      base[0] = 1'b1;
         FLAW_ODD_STRIDE:    stride[0] = 1'b1;
         FLAW_NARROW_STRIDE: stride = 32'(sw) * 2 - 2;
         FLAW_SHORT_BUFFER:  bytes = 32'(extent) - 1;
         FLAW_PAST_TOP:      base = 32'(64'h1_0000_0000 - extent) + 2;
         FLAW_NO_WIDTH:      sw_reg = '0;
         FLAW_NO_HEIGHT:     sh_reg = '0;
         default: ;
      endcase
      set_surface(base, stride, sw_reg, sh_reg, bytes);

      // Now and then the receiver stops for a long while and the sender floods.
      if (phase % 5 == 1) begin
         hold_asks++;
         flood_left = 60;
      end

      budget = $urandom_range(50, 110);
      first  = items_sent;
      while (items_sent - first < budget) begin
         if ($urandom_range(0, 3) == 0) begin
            push_random(1'($urandom_range(0, 1)));
         end else begin
            w = (sw <= 48 && $urandom_range(0, 9) == 0) ? sw
                                                        : $urandom_range(1, (sw < 6) ? sw : 6);
            h = $urandom_range(1, (sh < 4) ? sh : 4);
            push_item(FUNC_START, 16'($urandom_range(0, sw - w)),
                      16'($urandom_range(0, sh - h)), 16'(w), 16'(h), 16'($urandom));
            // Mostly just enough ticks to finish; sometimes the fill is left running.
            ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h)
                                                : w * h + $urandom_range(0, 2);
            repeat (ticks) push_random(($urandom_range(0, 15) == 0) ? FUNC_START : FUNC_TICK);
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      phase = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_random(FUNC_TICK);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h1234);

      set_surface(32'h1000, 32'd8, 16'd4, 16'd3, 32'd24);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd0, 16'd1, 16'h0000);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd0, 16'h0000);
      push_item(FUNC_START, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'h0000);
      push_item(FUNC_START, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'h0000);
      push_item(FUNC_START, 16'd3, 16'd2, 16'd1, 16'd1, 16'h0000);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd4, 16'd3, 16'hFFFF);
      push_random(FUNC_TICK);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd2, 16'd2, 16'hFFFF);
      repeat (4) push_random(FUNC_TICK);

      set_surface(32'h1001, 32'd8, 16'd4, 16'd3, 32'd24);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h00FF);
      set_surface(32'h1000, 32'd9, 16'd4, 16'd3, 32'd24);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h00FF);
      set_surface(32'h1000, 32'd6, 16'd4, 16'd3, 32'd24);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h00FF);
      set_surface(32'h1000, 32'd8, 16'd4, 16'd3, 32'd23);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h00FF);

      // A surface that ends exactly at the top of the address space, then one past it.
      set_surface(32'hFFFF_FFE8, 32'd8, 16'd4, 16'd3, 32'hFFFF_FFFF);
      push_item(FUNC_START, 16'd3, 16'd2, 16'd1, 16'd1, 16'hA5A5);
      push_random(FUNC_TICK);
      set_surface(32'hFFFF_FFEA, 32'd8, 16'd4, 16'd3, 32'hFFFF_FFFF);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'hA5A5);

      set_surface(32'h2000, 32'hFFFF_FFFE, 16'hFFFF, 16'd1, 32'hFFFF_FFFF);
      push_item(FUNC_START, 16'hFFFE, 16'd0, 16'd1, 16'd1, 16'h5A5A);
      push_random(FUNC_TICK);
      set_surface(32'h2000, 32'd8, 16'd0, 16'd3, 32'd24);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h5A5A);

      // The stride is rewritten in the middle of a fill; the next row address wraps.
      set_surface(32'h4000, 32'd8, 16'd4, 16'd3, 32'd24);
      push_item(FUNC_START, 16'd0, 16'd0, 16'd1, 16'd3, 16'h0F0F);
      push_random(FUNC_TICK);
      set_surface(32'h4000, 32'hFFFF_FFF0, 16'd4, 16'd3, 32'd24);
      repeat (2) push_random(FUNC_TICK);

      while (items_sent < 1300) begin
         run_phase(phase);
         phase++;
      end
      drain();

      $display("Run covered %0d request beats over %0d surface settings, %0d long stalls.",
               items_sent, settings_used, hold_asks);
      $display("Checked %0d response beats: %0d pixel writes, %0d fills, %0d refused starts.",
               beats_checked, pixels_checked, fills_started, starts_refused);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/rfe_pkg.sv
rtl/rfe_cmd_fifo.sv
rtl/rfe_front.sv
rtl/rfe_back.sv
rtl/rect_fill_engine_top.sv
tb/sv/rect_fill_checker.sv
tb/sv/tb.sv
